### sv/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg: shared widths for the demand paging translator
// Field widths of the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

   localparam int ADDR_W       = 16;
   localparam int PHYS_W       = 15;
   localparam int FRAME_FLD_W  = 7;
   localparam int PAGE_FLD_W   = 8;

endpackage

`default_nettype wire

### sv/dpt_if.sv
// ----------------------------------------------------------------------------
// dpt_if: request and response channel interfaces
// Valid/ready channels carrying one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpt_req_if
   import dpt_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] virt_addr;

   modport source (output valid, output virt_addr, input ready);
   modport sink   (input valid, input virt_addr, output ready);
endinterface

interface dpt_rsp_if
   import dpt_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [PHYS_W-1:0]      phys_addr;
   logic [FRAME_FLD_W-1:0] frame_number;
   logic                   page_fault;
   logic                   evicted_valid;
   logic [PAGE_FLD_W-1:0]  evicted_page;

   modport source (output valid, output phys_addr, output frame_number,
                   output page_fault, output evicted_valid, output evicted_page,
                   input ready);
   modport sink   (input valid, input phys_addr, input frame_number,
                   input page_fault, input evicted_valid, input evicted_page,
                   output ready);
endinterface

`default_nettype wire

### sv/dpt_ram.sv
// ----------------------------------------------------------------------------
// dpt_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ram
   import dpt_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output      logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### sv/demand_paging_translator_fifo_core.sv
// ----------------------------------------------------------------------------
// demand_paging_translator_fifo_core: page table lookup with FIFO replacement
// Translates logical addresses, loading missing pages round-robin into frames.
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one logical address per word; rsp_ch returns one word per
//   request with the physical address, frame, fault flag and evicted page.
//   one request is in flight at a time. the response register loads in
//   S_LOOK once the response register is free; a hit or a fault into a free
//   frame then returns to idle, a fault that evicts a resident page passes
//   through S_EVICT before idle, since the victim's page table entry is
//   cleared through the same write port that records the new mapping.
//   when PAGE_COUNT is not a power of two and smaller than the page number
//   range, the page number is reduced in two extra steps (a reciprocal
//   multiply in S_DIVQ, then a multiply and subtract in S_DIVR).
//   the page table memory sets the rate: one read, then no write on a hit,
//   one on a fault, two on an eviction. after reset it is cleared one entry
//   a cycle, all PAGE_COUNT entries, with req_ch.ready low. the frame owner
//   memory needs no clear: a fill flag marks when every frame was used once.
//   a stalled response holds in its register; the lookup of the next request
//   waits for it, but that request is still accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_paging_translator_fifo_core
   import dpt_pkg::*;
#(
   parameter int OFFSET_WIDTH = 8,
   parameter int PAGE_COUNT   = 256,
   parameter int FRAME_COUNT  = 128
) (
   input wire logic  clock,
   input wire logic  reset,
   dpt_req_if.sink   req_ch,
   dpt_rsp_if.source rsp_ch
);

   localparam int VW      = ADDR_W - OFFSET_WIDTH;
   localparam int PAGE_W  = $clog2(PAGE_COUNT);
   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam bit PC_POW2 = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;
   localparam bit NEED_DIV = !PC_POW2 && (PAGE_COUNT < (1 << VW));
   localparam int SH      = VW + PAGE_W;
   localparam int RECIP   = ((1 << SH) + PAGE_COUNT - 1) / PAGE_COUNT;
   localparam int MAP_W   = FRAME_W + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIVQ, S_DIVR, S_LOOK, S_EVICT
   } state_type;

   state_type               state_ff;
   logic [PAGE_W-1:0]       clr_ff;
   logic [FRAME_W-1:0]      victim_ff;
   logic                    wrapped_ff;
   logic [VW-1:0]           vpage_ff;
   logic [VW-1:0]           quot_ff;
   logic [OFFSET_WIDTH-1:0] offset_ff;
   logic [PAGE_W-1:0]       page_ff;
   logic [PAGE_W-1:0]       old_ff;

   logic                    rsp_valid_ff;
   logic [PHYS_W-1:0]       phys_ff;
   logic [FRAME_FLD_W-1:0]  frame_ff;
   logic                    fault_ff;
   logic                    ev_valid_ff;
   logic [PAGE_FLD_W-1:0]   ev_page_ff;

   logic [VW-1:0]           addr_page;
   logic [PAGE_W-1:0]       page_direct;
   logic [31:0]             recip_prod;
   logic [31:0]             quot_mul;
   logic [PAGE_W-1:0]       page_rem;
   logic [VW-1:0]           quot_in;

   logic                    map_we;
   logic [PAGE_W-1:0]       map_waddr;
   logic [MAP_W-1:0]        map_wdata;
   logic                    map_re;
   logic [PAGE_W-1:0]       map_raddr;
   logic [MAP_W-1:0]        map_rdata;
   logic                    own_we;
   logic                    own_re;
   logic [PAGE_W-1:0]       own_rdata;

   logic                    req_fire;
   logic                    out_free;
   logic                    hit;
   logic [FRAME_W-1:0]      frame_sel;

   assign addr_page   = req_ch.virt_addr[ADDR_W-1:OFFSET_WIDTH];
   assign page_direct = PAGE_W'(addr_page);

   // floor division by the page count through an exact reciprocal
   assign recip_prod = 32'(vpage_ff) * 32'(RECIP);
   assign quot_in    = VW'(recip_prod >> SH);
   assign quot_mul   = 32'(quot_ff) * 32'(PAGE_COUNT);
   assign page_rem   = PAGE_W'(32'(vpage_ff) - quot_mul);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign hit          = map_rdata[MAP_W-1];
   assign frame_sel    = hit ? map_rdata[FRAME_W-1:0] : victim_ff;

   always_comb begin
      map_re    = 1'b0;
      map_raddr = page_direct;
      if (state_ff == S_IDLE && req_fire && !NEED_DIV) begin
         map_re = 1'b1;
      end else if (state_ff == S_DIVR) begin
         map_re    = 1'b1;
         map_raddr = page_rem;
      end
      own_re = map_re;
   end

   always_comb begin
      map_we    = 1'b0;
      map_waddr = page_ff;
      map_wdata = {1'b1, victim_ff};
      own_we    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
         end
         S_LOOK: begin
            if (out_free && !hit) begin
               map_we = 1'b1;
               own_we = 1'b1;
            end
         end
         S_EVICT: begin
            map_we    = 1'b1;
            map_waddr = old_ff;
            map_wdata = '0;
         end
         default: begin
         end
      endcase
   end

   dpt_ram #(.DEPTH(PAGE_COUNT), .WIDTH(MAP_W)) u_page_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .re    (map_re),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   dpt_ram #(.DEPTH(FRAME_COUNT), .WIDTH(PAGE_W)) u_frame_owner (
      .clock (clock),
      .we    (own_we),
      .waddr (victim_ff),
      .wdata (page_ff),
      .re    (own_re),
      .raddr (victim_ff),
      .rdata (own_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         victim_ff    <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a response taken while the next one loads stays valid
         if (rsp_valid_ff && rsp_ch.ready && !(state_ff == S_LOOK && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == PAGE_W'(PAGE_COUNT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  vpage_ff  <= addr_page;
                  offset_ff <= req_ch.virt_addr[OFFSET_WIDTH-1:0];
                  page_ff   <= page_direct;
                  state_ff  <= NEED_DIV ? S_DIVQ : S_LOOK;
               end
            end
            S_DIVQ: begin
               quot_ff  <= quot_in;
               state_ff <= S_DIVR;
            end
            S_DIVR: begin
               page_ff  <= page_rem;
               state_ff <= S_LOOK;
            end
            S_LOOK: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  phys_ff      <= PHYS_W'({frame_sel, offset_ff});
                  frame_ff     <= FRAME_FLD_W'(frame_sel);
                  fault_ff     <= !hit;
                  ev_valid_ff  <= !hit && wrapped_ff;
                  ev_page_ff   <= (!hit && wrapped_ff) ? PAGE_FLD_W'(own_rdata) : '0;
                  if (hit) begin
                     state_ff <= S_IDLE;
                  end else begin
                     if (victim_ff == FRAME_W'(FRAME_COUNT - 1)) begin
                        victim_ff  <= '0;
                        wrapped_ff <= 1'b1;
                     end else begin
                        victim_ff <= victim_ff + 1'b1;
                     end
                     old_ff   <= own_rdata;
                     state_ff <= wrapped_ff ? S_EVICT : S_IDLE;
                  end
               end
            end
            S_EVICT: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.phys_addr     = phys_ff;
   assign rsp_ch.frame_number  = frame_ff;
   assign rsp_ch.page_fault    = fault_ff;
   assign rsp_ch.evicted_valid = ev_valid_ff;
   assign rsp_ch.evicted_page  = ev_page_ff;

   // an eviction only happens once every frame has been filled
   a_evict_after_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVICT |-> wrapped_ff)
      else $error("eviction before all frames were filled");

   // a fault always moves the replacement pointer
   a_victim_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && out_free && !hit) |=> victim_ff != $past(victim_ff))
      else $error("replacement pointer did not advance on a fault");

   // a hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !fault_ff) |-> !ev_valid_ff)
      else $error("eviction reported on a hit");

endmodule

`default_nettype wire

### tb/dpt_translation_checker.sv
// ----------------------------------------------------------------------------
// dpt_translation_checker: response checker for the demand paging translator
// Watches both channels. For each accepted request it computes the expected
// response from a private copy of the page table, the frame owners and the
// round-robin victim pointer. Each accepted response is compared against the
// oldest expected response.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_translation_checker
   import dpt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dpt_req_if        req_ch,
   dpt_rsp_if        rsp_ch,
   output int        mismatches,
   output int        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFS_W  = 8;
   localparam int PAGES  = 256;
   localparam int FRAMES = 128;

   typedef struct packed {
      logic [PHYS_W-1:0]      phys;
      logic [FRAME_FLD_W-1:0] frame;
      logic                   fault;
      logic                   ev_valid;
      logic [PAGE_FLD_W-1:0]  ev_page;
   } xlat_word_type;

   xlat_word_type          translations_due[$];
   bit                     page_live  [PAGES];
   logic [FRAME_FLD_W-1:0] page_frame [PAGES];
   bit                     frame_live [FRAMES];
   logic [PAGE_FLD_W-1:0]  frame_page [FRAMES];
   int unsigned            victim;

   function automatic xlat_word_type translate(input logic [ADDR_W-1:0] la);
      int unsigned   pg;
      int unsigned   frm;
      int unsigned   old;
      xlat_word_type w;
      pg = (la >> OFS_W) % PAGES;
      w  = '0;
      if (page_live[pg]) begin
         frm = page_frame[pg];
      end else begin
         w.fault = 1'b1;
         frm = victim;
         if (frame_live[frm]) begin
            // the displaced page loses its table entry
            old        = frame_page[frm];
            w.ev_valid = 1'b1;
            w.ev_page  = old[PAGE_FLD_W-1:0];
            page_live[old] = 1'b0;
         end
         frame_live[frm] = 1'b1;
         frame_page[frm] = pg[PAGE_FLD_W-1:0];
         page_live[pg]   = 1'b1;
         page_frame[pg]  = frm[FRAME_FLD_W-1:0];
         victim = (frm + 1 == FRAMES) ? 0 : frm + 1;
      end
      w.frame = frm[FRAME_FLD_W-1:0];
      w.phys  = PHYS_W'((frm << OFS_W) | (la & ((1 << OFS_W) - 1)));
      return w;
   endfunction

   always @(posedge clock) begin
      xlat_word_type got;
      xlat_word_type want;
      if (reset) begin
         translations_due.delete();
         for (int i = 0; i < PAGES; i++) begin
            page_live[i]  = 1'b0;
            page_frame[i] = '0;
         end
         for (int i = 0; i < FRAMES; i++) begin
            frame_live[i] = 1'b0;
            frame_page[i] = '0;
         end
         victim     = 0;
         mismatches = 0;
      end else begin
         // response first: it can never belong to a request taken this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.phys     = rsp_ch.phys_addr;
            got.frame    = rsp_ch.frame_number;
            got.fault    = rsp_ch.page_fault;
            got.ev_valid = rsp_ch.evicted_valid;
            got.ev_page  = rsp_ch.evicted_page;
            if (translations_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected word phys=%h frame=%0d fault=%b ev=%b/%0d",
                           $realtime, got.phys, got.frame, got.fault, got.ev_valid,
                           got.ev_page);
            end else begin
               want = translations_due.pop_front();
               if (got.phys !== want.phys || got.frame !== want.frame ||
                   got.fault !== want.fault || got.ev_valid !== want.ev_valid ||
                   got.ev_page !== want.ev_page) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch exp phys=%h frame=%0d fault=%b ev=%b/%0d",
                            $realtime, want.phys, want.frame, want.fault,
                            want.ev_valid, want.ev_page);
                     $display(", got phys=%h frame=%0d fault=%b ev=%b/%0d",
                              got.phys, got.frame, got.fault, got.ev_valid,
                              got.ev_page);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            translations_due.push_back(translate(req_ch.virt_addr));
      end
      outstanding = translations_due.size();
   end

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for demand_paging_translator_fifo_core
// Drives directed and random logical addresses with random idling on both
// channels, a long response hold-off and a full drain, then reports the
// verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import dpt_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_CYCLES     = 64;
   localparam int WORDS_PER_PHASE = 212;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_request  = 0;

   logic [PAGE_FLD_W-1:0] recent_pages [16];
   int                    recent_idx;

   logic [ADDR_W-1:0] directed_addrs [18] = '{
      16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h0100, 16'h01FF,
      16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8080,
      16'h7F00, 16'hFE80, 16'h0000, 16'hFFFF, 16'h5555, 16'h0200
   };

   dpt_req_if req_ch ();
   dpt_rsp_if rsp_ch ();

   demand_paging_translator_fifo_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dpt_translation_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("demand_paging_translator_fifo_core test failed");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_word(input logic [ADDR_W-1:0] la);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.virt_addr <= la;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // idle the request side until every response is back
   task automatic drain;
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // recently picked pages (45%, mostly hits) mixed with fresh pages (faults, evictions)
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [PAGE_FLD_W-1:0] pg;
      if ($urandom_range(0, 99) < 45) begin
         pg = recent_pages[$urandom_range(0, 15)];
      end else begin
         pg = PAGE_FLD_W'($urandom_range(0, 255));
         recent_pages[recent_idx] = pg;
         recent_idx = (recent_idx + 1) % 16;
      end
      return {pg, 8'($urandom)};
   endfunction

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.virt_addr = '0;
      recent_idx       = 0;
      foreach (recent_pages[i]) recent_pages[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_addrs[i]) send_word(directed_addrs[i]);

      // stall the response side long enough to back up the request side
      hold_request = HOLD_CYCLES;
      repeat (10) send_word(pick_address());

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 9 : 0;
         rsp_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 9 : 0;
         for (int i = 0; i < WORDS_PER_PHASE; i++) send_word(pick_address());
         if (ph == 1) drain();
      end

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("demand_paging_translator_fifo_core test passed");
      end else begin
         $display("demand_paging_translator_fifo_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
